[src/falkc_pkg.sv]
// ----------------------------------------------------------------------------
// falkc_pkg
// Shared types and fixed field widths of the fully associative LRU key cache.
// ----------------------------------------------------------------------------
package falkc_pkg;

    // fixed payload widths
    localparam int KEY_W    = 64;
    localparam int HANDLE_W = 32;
    localparam int SIZE_W   = 17;
    localparam int SLOT_W   = 3;

    // request kinds
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    // controller states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_UPDATE
    } falkc_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;   // take the item and register the compare vectors
        logic update;    // select the slot, age the ranks, write the result
    } falkc_cmd_t;

endpackage

[src/fully_associative_lru_key_cache.sv]
// Result: done strobes for one cycle. An item is accepted in the idle state,
// the update state follows, and done is registered from the update state.
// Flow: no new item is taken while busy. A parallel key compare runs in the
// accept cycle; slot selection, age update and slot write follow in update.
// Reset: age ranks load their slot index and the fill count clears; key and
// data storage is not cleared. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// fully_associative_lru_key_cache
// Fully associative key cache with exact LRU age ranks: lookup and insert.
// ----------------------------------------------------------------------------
module fully_associative_lru_key_cache #(
    parameter int ENTRIES  = 8,
    parameter int KEY_BITS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             kind,
    input  logic [falkc_pkg::KEY_W-1:0]      key,
    input  logic [falkc_pkg::HANDLE_W-1:0]   object_handle,
    input  logic [falkc_pkg::SIZE_W-1:0]     object_size,
    output logic                             done,
    output logic                             found,
    output logic [falkc_pkg::SLOT_W-1:0]     slot,
    output logic [falkc_pkg::HANDLE_W-1:0]   found_handle,
    output logic [falkc_pkg::SIZE_W-1:0]     found_size
);
    import falkc_pkg::*;

    falkc_cmd_t cmd;

    // sequence each item
    falkc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // store, compare and age
    falkc_datapath #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .kind          (kind),
        .key           (key),
        .object_handle (object_handle),
        .object_size   (object_size),
        .found         (found),
        .slot          (slot),
        .found_handle  (found_handle),
        .found_size    (found_size)
    );

endmodule

[src/falkc_ctrl.sv]
// ----------------------------------------------------------------------------
// falkc_ctrl
// Two-state sequencer: accept an item, then run the update cycle and strobe
// the result.
// ----------------------------------------------------------------------------
module falkc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output logic                  done,
    output falkc_pkg::falkc_cmd_t cmd
);
    import falkc_pkg::*;

    falkc_state_t state_reg;
    falkc_state_t state_next;
    logic         done_reg;
    logic         done_next;

    // hold state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // advance on accept, return after the update cycle
    always_comb
    begin
        state_next  = state_reg;
        busy        = 1'b0;
        cmd.capture = 1'b0;
        cmd.update  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = start;
                if (start)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                busy       = 1'b1;
                cmd.update = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        done_next = cmd.update;
    end

    assign done = done_reg;

endmodule

[src/falkc_datapath.sv]
// ----------------------------------------------------------------------------
// falkc_datapath
// Slot storage, parallel key compare, age ranks and the result registers.
// ----------------------------------------------------------------------------
module falkc_datapath #(
    parameter int ENTRIES  = 8,
    parameter int KEY_BITS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  falkc_pkg::falkc_cmd_t            cmd,
    input  logic                             kind,
    input  logic [falkc_pkg::KEY_W-1:0]      key,
    input  logic [falkc_pkg::HANDLE_W-1:0]   object_handle,
    input  logic [falkc_pkg::SIZE_W-1:0]     object_size,
    output logic                             found,
    output logic [falkc_pkg::SLOT_W-1:0]     slot,
    output logic [falkc_pkg::HANDLE_W-1:0]   found_handle,
    output logic [falkc_pkg::SIZE_W-1:0]     found_size
);
    import falkc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // slot storage
    logic [KEY_BITS-1:0] key_store [ENTRIES];
    logic [HANDLE_W-1:0] handle_mem [ENTRIES];
    logic [SIZE_W-1:0]   size_mem [ENTRIES];
    logic [IDX_W-1:0]    age_reg [ENTRIES];
    logic [IDX_W-1:0]    age_next [ENTRIES];
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    fill_next;

    // captured item and compare vectors
    logic                kind_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [HANDLE_W-1:0] handle_in_reg;
    logic [SIZE_W-1:0]   size_in_reg;
    logic [ENTRIES-1:0]  hit_vec_reg;
    logic [ENTRIES-1:0]  hit_vec_next;
    logic [ENTRIES-1:0]  old_vec_reg;
    logic [ENTRIES-1:0]  old_vec_next;

    // result registers
    logic                found_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [HANDLE_W-1:0] found_handle_reg;
    logic [SIZE_W-1:0]   found_size_reg;

    // update-cycle selection
    logic                hit_any;
    logic [IDX_W-1:0]    hit_idx;
    logic                old_any;
    logic [IDX_W-1:0]    old_idx;
    logic                is_full;
    logic                touch;
    logic                write_en;
    logic [IDX_W-1:0]    tgt;
    logic [IDX_W-1:0]    level;
    logic [IDX_W+2:0]    tgt_wide;
    logic                hit_found;

    // compare the incoming key against every filled slot, flag the oldest
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec_next[i] = (CNT_W'(i) < fill_reg) &&
                              (key_store[i] == key[KEY_BITS-1:0]);
            old_vec_next[i] = (age_reg[i] == IDX_W'(ENTRIES - 1));
        end
    end

    // pick lowest matching slot and lowest oldest slot
    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        old_any = 1'b0;
        old_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (hit_vec_reg[i])
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (old_vec_reg[i])
            begin
                old_any = 1'b1;
                old_idx = IDX_W'(i);
            end
        end
    end

    // choose the slot to touch and compute new ranks
    always_comb
    begin
        is_full   = (fill_reg == CNT_W'(ENTRIES));
        fill_next = fill_reg;
        touch     = 1'b0;
        write_en  = 1'b0;
        tgt       = '0;
        priority if (kind_reg == KIND_LOOKUP)
        begin
            touch = hit_any;
            tgt   = hit_idx;
        end
        else if (!is_full)
        begin
            touch     = 1'b1;
            write_en  = 1'b1;
            tgt       = fill_reg[IDX_W-1:0];
            fill_next = fill_reg + CNT_W'(1);
        end
        else
        begin
            touch    = old_any;
            write_en = old_any;
            tgt      = old_idx;
        end

        level = age_reg[tgt];
        for (int i = 0; i < ENTRIES; i++)
        begin
            age_next[i] = age_reg[i];
            if (touch)
            begin
                if (IDX_W'(i) == tgt)
                begin
                    age_next[i] = '0;
                end
                else if ((CNT_W'(i) < fill_reg) && (age_reg[i] < level))
                begin
                    age_next[i] = age_reg[i] + IDX_W'(1);
                end
            end
        end

        tgt_wide  = (IDX_W + 3)'(tgt);
        hit_found = (kind_reg == KIND_LOOKUP) && hit_any;
    end

    // hold ranks and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                age_reg[i] <= IDX_W'(i);
            end
            fill_reg <= '0;
        end
        else if (cmd.update)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                age_reg[i] <= age_next[i];
            end
            fill_reg <= fill_next;
        end
    end

    // capture the item and its compare vectors
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg      <= kind;
            key_reg       <= key[KEY_BITS-1:0];
            handle_in_reg <= object_handle;
            size_in_reg   <= object_size;
            hit_vec_reg   <= hit_vec_next;
            old_vec_reg   <= old_vec_next;
        end
    end

    // write the chosen slot, read stored data and register the result
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            if (write_en)
            begin
                key_store[tgt]  <= key_reg;
                handle_mem[tgt] <= handle_in_reg;
                size_mem[tgt]   <= size_in_reg;
            end
            found_reg        <= hit_found;
            slot_reg         <= touch ? tgt_wide[SLOT_W-1:0] : '0;
            found_handle_reg <= hit_found ? handle_mem[tgt] : '0;
            found_size_reg   <= hit_found ? size_mem[tgt] : '0;
        end
    end

    assign found        = found_reg;
    assign slot         = slot_reg;
    assign found_handle = found_handle_reg;
    assign found_size   = found_size_reg;

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fully associative LRU key cache. A queue of
// lookup and insert items feeds a driver that honors start/busy; a monitor
// predicts each accepted item against a shadow copy of the slots and their
// age ranks, and checks every done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    import falkc_pkg::*;

    localparam int NUM_SLOTS   = 8;
    localparam int POOL_SIZE   = 12;
    localparam int RANDOM_ITEMS = 1530;
    localparam int QUIET_TAIL  = 120;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 6;

    typedef struct packed {
        logic                kind;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] obj_handle;
        logic [SIZE_W-1:0]   obj_size;
    } cache_req_t;

    typedef struct packed {
        logic                found;
        logic [SLOT_W-1:0]   slot;
        logic [HANDLE_W-1:0] obj_handle;
        logic [SIZE_W-1:0]   obj_size;
    } cache_reply_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                kind;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] object_handle;
    logic [SIZE_W-1:0]   object_size;
    logic                done;
    logic                found;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] found_handle;
    logic [SIZE_W-1:0]   found_size;

    // shadow copy of the cache contents
    logic [KEY_W-1:0]    shadow_key [NUM_SLOTS];
    logic [HANDLE_W-1:0] shadow_handle [NUM_SLOTS];
    logic [SIZE_W-1:0]   shadow_size [NUM_SLOTS];
    logic [SLOT_W-1:0]   shadow_age [NUM_SLOTS];
    int                  shadow_fill;

    cache_req_t   pending_items[$];
    cache_reply_t expected_replies[$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    logic taken_last;
    int   idle_left;
    int   mismatch_count;
    int   cycle_count;

    fully_associative_lru_key_cache #(
        .ENTRIES  (NUM_SLOTS),
        .KEY_BITS (KEY_W)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .key           (key),
        .object_handle (object_handle),
        .object_size   (object_size),
        .done          (done),
        .found         (found),
        .slot          (slot),
        .found_handle  (found_handle),
        .found_size    (found_size)
    );

    // free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h",
                 cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // move slot s to age 0, aging every filled slot younger than it
    task automatic promote_slot(input int s);
        logic [SLOT_W-1:0] level;
        level = shadow_age[s];
        for (int i = 0; i < shadow_fill && i < NUM_SLOTS; i++)
        begin
            if (shadow_age[i] < level)
                shadow_age[i] = shadow_age[i] + 1'b1;
        end
        shadow_age[s] = '0;
    endtask

    // apply one item to the shadow cache and return the reply it causes
    task automatic predict_cache_access(input cache_req_t req, output cache_reply_t rep);
        int s;
        rep = '0;
        if (req.kind == KIND_LOOKUP)
        begin
            // lowest-numbered matching slot wins
            for (int i = 0; i < shadow_fill && i < NUM_SLOTS; i++)
            begin
                if (shadow_key[i] == req.key)
                begin
                    rep.found      = 1'b1;
                    rep.slot       = SLOT_W'(i);
                    rep.obj_handle = shadow_handle[i];
                    rep.obj_size   = shadow_size[i];
                    promote_slot(i);
                    return;
                end
            end
            return;
        end
        // insert: next free slot, else the least recent one
        s = -1;
        if (shadow_fill < NUM_SLOTS)
            s = shadow_fill;
        else
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (s < 0 && shadow_age[i] == SLOT_W'(NUM_SLOTS - 1))
                    s = i;
            end
        end
        if (s < 0)
            return;
        shadow_key[s]    = req.key;
        shadow_handle[s] = req.obj_handle;
        shadow_size[s]   = req.obj_size;
        promote_slot(s);
        if (shadow_fill < NUM_SLOTS)
            shadow_fill++;
        rep.slot = SLOT_W'(s);
    endtask

    task automatic queue_item(input logic k, input logic [KEY_W-1:0] kv,
                              input logic [HANDLE_W-1:0] h, input logic [SIZE_W-1:0] sz);
        cache_req_t req;
        req.kind       = k;
        req.key        = kv;
        req.obj_handle = h;
        req.obj_size   = sz;
        pending_items.push_back(req);
    endtask

    // drive items on the falling edge; hold an item until it is taken
    always @(negedge clk)
    begin
        cache_req_t req;
        if (!rst_n)
            start <= 1'b0;
        else if (start && !taken_last)
            start <= 1'b1;
        else if (idle_left > 0)
        begin
            start <= 1'b0;
            idle_left--;
        end
        else if (pending_items.size() > QUIET_TAIL && $urandom_range(0, 4) == 0)
        begin
            start     <= 1'b0;
            idle_left = $urandom_range(0, 3);
        end
        else if (pending_items.size() > 0)
        begin
            req = pending_items.pop_front();
            start         <= 1'b1;
            kind          <= req.kind;
            key           <= req.key;
            object_handle <= req.obj_handle;
            object_size   <= req.obj_size;
        end
        else
            start <= 1'b0;
    end

    // check replies first, then predict the item taken at this edge
    always @(posedge clk)
    begin
        cache_req_t   req;
        cache_reply_t got;
        cache_reply_t want;
        if (rst_n && done)
        begin
            got.found      = found;
            got.slot       = slot;
            got.obj_handle = found_handle;
            got.obj_size   = found_size;
            if (expected_replies.size() == 0)
                report_mismatch("reply with none expected", 64'(got.slot), 64'd0);
            else
            begin
                want = expected_replies.pop_front();
                if (got.found !== want.found)
                    report_mismatch("found", 64'(got.found), 64'(want.found));
                if (got.slot !== want.slot)
                    report_mismatch("slot", 64'(got.slot), 64'(want.slot));
                if (got.obj_handle !== want.obj_handle)
                    report_mismatch("found_handle", 64'(got.obj_handle),
                                    64'(want.obj_handle));
                if (got.obj_size !== want.obj_size)
                    report_mismatch("found_size", 64'(got.obj_size), 64'(want.obj_size));
            end
        end
        if (rst_n && start && !busy)
        begin
            req.kind       = kind;
            req.key        = key;
            req.obj_handle = object_handle;
            req.obj_size   = object_size;
            predict_cache_access(req, want);
            expected_replies.push_back(want);
        end
        taken_last <= rst_n && start && !busy;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        logic [KEY_W-1:0] kv;
        int               pick;
        start          = 1'b0;
        kind           = KIND_LOOKUP;
        key            = '0;
        object_handle  = '0;
        object_size    = '0;
        rst_n          = 1'b0;
        taken_last     = 1'b0;
        idle_left      = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            shadow_key[i]    = '0;
            shadow_handle[i] = '0;
            shadow_size[i]   = '0;
            shadow_age[i]    = SLOT_W'(i);
        end
        shadow_fill = 0;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};

        // directed: empty miss, extreme fields, duplicate keys, fill, eviction
        queue_item(KIND_LOOKUP, '0, '0, '0);
        queue_item(KIND_INSERT, '0, '0, '0);
        queue_item(KIND_INSERT, '1, '1, '1);
        queue_item(KIND_INSERT, '0, 32'h1234_5678, 17'h00005);
        queue_item(KIND_LOOKUP, '0, '1, '1);
        queue_item(KIND_LOOKUP, '1, '0, '0);
        for (int i = 0; i < 5; i++)
            queue_item(KIND_INSERT, key_pool[i], $urandom, SIZE_W'($urandom));
        queue_item(KIND_LOOKUP, key_pool[0], '0, '0);
        queue_item(KIND_LOOKUP, key_pool[3], '0, '0);
        queue_item(KIND_INSERT, key_pool[5], $urandom, SIZE_W'($urandom));
        queue_item(KIND_INSERT, key_pool[6], $urandom, SIZE_W'($urandom));
        queue_item(KIND_INSERT, key_pool[7], '1, '1);
        queue_item(KIND_LOOKUP, 64'h5555_aaaa_5555_aaaa, '1, '1);
        queue_item(KIND_LOOKUP, key_pool[5], '0, '0);
        queue_item(KIND_LOOKUP, '0, '0, '0);
        queue_item(KIND_LOOKUP, key_pool[7], '0, '0);
        queue_item(KIND_INSERT, key_pool[0], '0, '0);
        queue_item(KIND_LOOKUP, key_pool[0], '0, '0);

        // random: mostly pooled keys for hits, some near misses and noise
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 39) == 0)
                key_pool[$urandom_range(0, POOL_SIZE - 1)] = {$urandom, $urandom};
            pick = $urandom_range(0, 19);
            kv   = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (pick == 0)
                kv = {$urandom, $urandom};
            else if (pick == 1)
                kv = kv ^ (64'd1 << $urandom_range(0, KEY_W - 1));
            queue_item(($urandom_range(0, 9) < 6) ? KIND_LOOKUP : KIND_INSERT, kv,
                       $urandom, SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1)));
        end

        // release reset away from the active edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // drain
        while (pending_items.size() != 0 || start)
            @(posedge clk);
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
src/falkc_pkg.sv
src/falkc_ctrl.sv
src/falkc_datapath.sv
src/fully_associative_lru_key_cache.sv
verif/tb_top.sv
